// ===== src/sgs_pkg.sv =====
// ============================================================================
// sgs_pkg: shared types and constants of the segregation grid step unit
// Holds command and result codes, generator constants and the share table.
// ============================================================================
package sgs_pkg;

   localparam int FRAC_W = 16;

   // Command codes on req_mode.
   localparam logic [1:0] MODE_WRITE = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_ROUND = 2'd2;
   localparam logic [1:0] MODE_STATS = 2'd3;

   // Result tags.
   localparam logic [2:0] TAG_ACK     = 3'd0;
   localparam logic [2:0] TAG_VALUE   = 3'd1;
   localparam logic [2:0] TAG_ROUND   = 3'd2;
   localparam logic [2:0] TAG_MEAN    = 3'd3;
   localparam logic [2:0] TAG_UNHAPPY = 3'd4;
   localparam logic [2:0] TAG_TILE    = 3'd5;

   // Cell contents.
   localparam logic [1:0] CELL_EMPTY = 2'd0;
   localparam logic [1:0] CELL_MAX   = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_TOLERANCE = 1'b0;
   localparam logic CSR_SEED      = 1'b1;

   localparam logic [8:0]  TOL_RESET  = 9'd77;
   localparam logic [8:0]  TOL_ONE    = 9'd256;
   localparam logic [31:0] SEED_RESET = 32'd1253891825;
   localparam logic [31:0] LCG_MUL    = 32'd1664525;
   localparam logic [31:0] LCG_INC    = 32'd1013904223;

   localparam logic [10:0] MOVES_MAX = 11'd2047;
   localparam logic [15:0] GEN_MAX   = 16'hFFFF;
   localparam logic [4:0]  STAT_LAST = 5'd17;

   // Same-type share floor(s * 65536 / t) in Q1.16, 1.0 when there are no
   // occupied neighbors. s never exceeds t, and t is at most eight.
   function automatic logic [16:0] share_q16(input logic [3:0] s, input logic [3:0] t);
      logic [16:0] v;
      v = '0;
      if (t == 4'd0 || s == t) begin
         v = 17'h10000;
      end else begin
         case (t)
            4'd2: v = 17'(s) << 15;
            4'd4: v = 17'(s) << 14;
            4'd8: v = 17'(s) << 13;
            4'd3: begin
               case (s)
                  4'd1: v = 17'd21845;
                  4'd2: v = 17'd43690;
                  default: v = '0;
               endcase
            end
            4'd5: begin
               case (s)
                  4'd1: v = 17'd13107;
                  4'd2: v = 17'd26214;
                  4'd3: v = 17'd39321;
                  4'd4: v = 17'd52428;
                  default: v = '0;
               endcase
            end
            4'd6: begin
               case (s)
                  4'd1: v = 17'd10922;
                  4'd2: v = 17'd21845;
                  4'd3: v = 17'd32768;
                  4'd4: v = 17'd43690;
                  4'd5: v = 17'd54613;
                  default: v = '0;
               endcase
            end
            4'd7: begin
               case (s)
                  4'd1: v = 17'd9362;
                  4'd2: v = 17'd18724;
                  4'd3: v = 17'd28086;
                  4'd4: v = 17'd37449;
                  4'd5: v = 17'd46811;
                  4'd6: v = 17'd56173;
                  default: v = '0;
               endcase
            end
            default: v = '0;
         endcase
      end
      return v;
   endfunction

endpackage

// ===== src/sgs_div.sv =====
// ============================================================================
// sgs_div: restoring divider for the statistics
// One quotient bit per cycle; the result saturates to 16 bits and a zero
// divisor gives zero.
// ============================================================================
module sgs_div #(
   parameter int NW = 29,
   parameter int DW = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NW-1:0]               num,
   input  logic [DW-1:0]               den,
   output logic                        done,
   output logic [sgs_pkg::FRAC_W-1:0]  quot
);

   localparam int CNTW = $clog2(NW + 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic                       zero_ff, zero_in;
   logic [CNTW-1:0]            cnt_ff, cnt_in;
   logic [DW-1:0]              rem_ff, rem_in;
   logic [DW-1:0]              den_ff, den_in;
   logic [NW-1:0]              quo_ff, quo_in;
   logic [sgs_pkg::FRAC_W-1:0] quot_ff, quot_in;

   logic [DW:0]   rem_sh;
   logic [DW:0]   diff;
   logic          ge;
   logic [NW-1:0] quo_nx;

   assign rem_sh = {rem_ff, quo_ff[NW-1]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign ge     = rem_sh >= {1'b0, den_ff};
   assign quo_nx = {quo_ff[NW-2:0], ge};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(NW);
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         zero_in = (den == '0);
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
         quo_in = quo_nx;
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (zero_ff) begin
               quot_in = '0;
            end else if (|quo_nx[NW-1:sgs_pkg::FRAC_W]) begin
               quot_in = '1;
            end else begin
               quot_in = quo_nx[sgs_pkg::FRAC_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== src/segregation_grid_step_unit.sv =====
// ============================================================================
// segregation_grid_step_unit: toroidal segregation grid with relocation
// Holds the grid in a cell memory and the unhappy and empty lists in two list
// memories; a sequencer walks them for rounds and statistics.
// ============================================================================
// A write acks in the cycle after acceptance; a read registers the cell data, then the result word.
// A round scans every cell, then shuffles the unhappy and empty lists and moves the agents;
// statistics scan every cell, then run 18 divisions, one result word each.
// Only one command at a time; the next is taken once the last word of it shows.
// After reset a clearing pass empties every cell of the grid, busy high.
// Results cannot be stalled: each word shows for one cycle.
module segregation_grid_step_unit #(
   parameter int GRID_SIDE = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [4:0]  req_cell_x,
   input  logic [4:0]  req_cell_y,
   input  logic [1:0]  req_cell_value,
   output logic        rsp_valid,
   output logic [2:0]  rsp_result_tag,
   output logic [3:0]  rsp_tile_index,
   output logic [15:0] rsp_fraction,
   output logic [1:0]  rsp_read_value,
   output logic [10:0] rsp_moves,
   output logic        rsp_quiet,
   output logic [15:0] rsp_round_count,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int NCELLS = GRID_SIDE * GRID_SIDE;
   localparam int CW     = $clog2(NCELLS);
   localparam int XW     = $clog2(GRID_SIDE);
   localparam int CNTW   = $clog2(NCELLS + 1);
   localparam int TS     = GRID_SIDE / 4;
   localparam int TSW    = $clog2(TS);
   localparam int TNW    = $clog2(TS * TS + 1);
   localparam int SUMW   = CNTW + 16;
   localparam int TSUMW  = TNW + 16;

   // Neighbor offset codes: minus one, none, plus one.
   localparam logic [1:0] D_MINUS = 2'd0;
   localparam logic [1:0] D_NONE  = 2'd1;
   localparam logic [1:0] D_PLUS  = 2'd2;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_READ, S_SCAN, S_SH_PICK, S_SH_RNG, S_SH_J,
      S_SH_RDI, S_SH_RDJ, S_SH_WI, S_SH_WJ, S_MV_CHK, S_MV_RD, S_MV_SRC,
      S_MV_WD, S_MV_WS, S_RND_DONE, S_DIV_GO, S_DIV_WAIT
   } state_type;

   // Memories: the grid and the two lists of cell numbers.
   logic [1:0]    cell_mem [NCELLS];
   logic [CW-1:0] ul_mem   [NCELLS];
   logic [CW-1:0] el_mem   [NCELLS];

   logic          cell_we, ul_we, el_we;
   logic [CW-1:0] cell_waddr, cell_raddr, ul_waddr, ul_raddr, el_waddr, el_raddr;
   logic [1:0]    cell_wdata;
   logic [CW-1:0] ul_wdata, el_wdata;
   logic [1:0]    cell_rdata_ff;
   logic [CW-1:0] ul_rdata_ff, el_rdata_ff;

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      cell_rdata_ff <= cell_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (ul_we) begin
         ul_mem[ul_waddr] <= ul_wdata;
      end
      ul_rdata_ff <= ul_mem[ul_raddr];
   end

   always_ff @(posedge clock) begin
      if (el_we) begin
         el_mem[el_waddr] <= el_wdata;
      end
      el_rdata_ff <= el_mem[el_raddr];
   end

   // Sequencer registers.
   state_type      state_ff, state_in;
   logic           stats_ff, stats_in;
   logic [CW-1:0]  c_ff, c_in;
   logic [XW-1:0]  x_ff, x_in, y_ff, y_in;
   logic [3:0]     k_ff, k_in;
   logic [1:0]     me_ff, me_in;
   logic [3:0]     s_ff, s_in, t_ff, t_in;
   logic [CNTW-1:0] nu_ff, nu_in, ne_ff, ne_in;
   logic [TSW-1:0] tdx_ff, tdx_in, tdy_ff, tdy_in;
   logic [2:0]     tqx_ff, tqx_in, tqy_ff, tqy_in;
   logic [8:0]     tol_ff, tol_in;
   logic [31:0]    rng_ff, rng_in;
   logic [CW-1:0]  i_ff, i_in, j_ff, j_in, ai_ff, ai_in;
   logic [CW-1:0]  src_ff, src_in, dst_ff, dst_in;
   logic           lsel_ff, lsel_in;
   logic           rd_inside_ff, rd_inside_in;
   logic [15:0]    gen_ff, gen_in;
   logic [SUMW-1:0] sum_ff, sum_in;
   logic [CNTW-1:0] occ_ff, occ_in, unh_ff, unh_in;
   logic [TSUMW-1:0] tsum_ff [16];
   logic [TSUMW-1:0] tsum_in [16];
   logic [TNW-1:0]   tcnt_ff [16];
   logic [TNW-1:0]   tcnt_in [16];
   logic [4:0]     didx_ff, didx_in;

   // Registered result word.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_tag_ff, rsp_tag_in;
   logic [3:0]  rsp_tile_ff, rsp_tile_in;
   logic [15:0] rsp_frac_ff, rsp_frac_in;
   logic [1:0]  rsp_rv_ff, rsp_rv_in;
   logic [10:0] rsp_mv_ff, rsp_mv_in;
   logic        rsp_quiet_ff, rsp_quiet_in;
   logic [15:0] rsp_rc_ff, rsp_rc_in;
   logic        rsp_last_ff, rsp_last_in;

   // Divider interface.
   logic              div_start, div_done;
   logic [SUMW-1:0]   div_num;
   logic [CNTW-1:0]   div_den;
   logic [15:0]       div_quot;

   sgs_div #(
      .NW (SUMW),
      .DW (CNTW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   function automatic logic [XW-1:0] wrap_step(input logic [XW-1:0] v, input logic [1:0] d);
      logic [XW-1:0] r;
      r = v;
      case (d)
         D_MINUS: r = (v == '0) ? XW'(GRID_SIDE - 1) : v - XW'(1);
         D_PLUS:  r = (v == XW'(GRID_SIDE - 1)) ? '0 : v + XW'(1);
         default: r = v;
      endcase
      return r;
   endfunction

   function automatic logic [CW-1:0] addr_of(input logic [XW-1:0] yv, input logic [XW-1:0] xv);
      return CW'(CW'(yv) * CW'(GRID_SIDE)) + CW'(xv);
   endfunction

   // Combinational helpers.
   logic          accept, req_inside, unhappy, in_tile;
   logic [XW-1:0] req_x, req_y;
   logic [1:0]    dxc, dyc;
   logic [3:0]    s_nx, t_nx;
   logic [16:0]   share;
   logic [8:0]    tol_eff;
   logic [12:0]   tol_prod;
   logic [3:0]    tidx;
   logic [CNTW-1:0] ne_dec, nu_dec, n_sel;
   logic [CNTW-1:0] ip1;
   logic [63:0]   jprod;
   logic [63:0]   rprod;
   logic [CW-1:0] lst_rdata;
   logic [10:0]   mv_sat;
   logic [15:0]   gen_nx;

   assign accept     = start && (state_ff == S_IDLE);
   assign req_x      = XW'({2'b00, req_cell_x});
   assign req_y      = XW'({2'b00, req_cell_y});
   assign req_inside = ({2'b00, req_cell_x} < 7'(GRID_SIDE))
                    && ({2'b00, req_cell_y} < 7'(GRID_SIDE));

   // Neighbor order over one cell: center first, then the eight around it.
   always_comb begin
      case (k_ff)
         4'd1:    begin dxc = D_MINUS; dyc = D_MINUS; end
         4'd2:    begin dxc = D_NONE;  dyc = D_MINUS; end
         4'd3:    begin dxc = D_PLUS;  dyc = D_MINUS; end
         4'd4:    begin dxc = D_MINUS; dyc = D_NONE;  end
         4'd5:    begin dxc = D_PLUS;  dyc = D_NONE;  end
         4'd6:    begin dxc = D_MINUS; dyc = D_PLUS;  end
         4'd7:    begin dxc = D_NONE;  dyc = D_PLUS;  end
         4'd8:    begin dxc = D_PLUS;  dyc = D_PLUS;  end
         default: begin dxc = D_NONE;  dyc = D_NONE;  end
      endcase
   end

   // The read data of step k belongs to the neighbor issued at step k-1.
   always_comb begin
      s_nx = s_ff;
      t_nx = t_ff;
      if (k_ff >= 4'd2 && cell_rdata_ff != sgs_pkg::CELL_EMPTY) begin
         t_nx = t_ff + 4'd1;
         if (cell_rdata_ff == me_ff) begin
            s_nx = s_ff + 4'd1;
         end
      end
   end

   assign tol_eff  = (tol_ff > sgs_pkg::TOL_ONE) ? sgs_pkg::TOL_ONE : tol_ff;
   assign tol_prod = 13'(tol_eff) * 13'(t_nx);
   assign unhappy  = 13'({s_nx, 8'b0}) < tol_prod;
   assign share    = sgs_pkg::share_q16(s_nx, t_nx);
   assign in_tile  = !tqx_ff[2] && !tqy_ff[2];
   assign tidx     = {tqy_ff[1:0], tqx_ff[1:0]};

   assign ne_dec    = ne_ff - CNTW'(1);
   assign nu_dec    = nu_ff - CNTW'(1);
   assign n_sel     = lsel_ff ? ne_ff : nu_ff;
   assign ip1       = CNTW'(i_ff) + CNTW'(1);
   assign jprod     = 64'(rng_ff) * 64'(ip1);
   assign rprod     = 64'(rng_ff) * 64'(sgs_pkg::LCG_MUL);
   assign lst_rdata = lsel_ff ? el_rdata_ff : ul_rdata_ff;
   assign gen_nx    = (gen_ff == sgs_pkg::GEN_MAX) ? gen_ff : gen_ff + 16'd1;

   // Agents moved: every unhappy agent when an empty cell exists, else none.
   always_comb begin
      if (ne_ff == '0) begin
         mv_sat = '0;
      end else if (32'(nu_ff) > 32'(sgs_pkg::MOVES_MAX)) begin
         mv_sat = sgs_pkg::MOVES_MAX;
      end else begin
         mv_sat = 11'(nu_ff);
      end
   end

   // Divider operands: the mean, the unhappy fraction, then the tile at the
   // head of the tile accumulators, which shift down after each tile word.
   always_comb begin
      case (didx_ff)
         5'd0: begin
            div_num = sum_ff;
            div_den = occ_ff;
         end
         5'd1: begin
            div_num = SUMW'(unh_ff) << 16;
            div_den = occ_ff;
         end
         default: begin
            div_num = SUMW'(tsum_ff[0]);
            div_den = CNTW'(tcnt_ff[0]);
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      stats_in     = stats_ff;
      c_in         = c_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      k_in         = k_ff;
      me_in        = me_ff;
      s_in         = s_ff;
      t_in         = t_ff;
      nu_in        = nu_ff;
      ne_in        = ne_ff;
      tdx_in       = tdx_ff;
      tdy_in       = tdy_ff;
      tqx_in       = tqx_ff;
      tqy_in       = tqy_ff;
      tol_in       = tol_ff;
      rng_in       = rng_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      ai_in        = ai_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      lsel_in      = lsel_ff;
      rd_inside_in = rd_inside_ff;
      gen_in       = gen_ff;
      sum_in       = sum_ff;
      occ_in       = occ_ff;
      unh_in       = unh_ff;
      didx_in      = didx_ff;
      for (int n = 0; n < 16; n++) begin
         tsum_in[n] = tsum_ff[n];
         tcnt_in[n] = tcnt_ff[n];
      end
      rsp_valid_in = 1'b0;
      rsp_tag_in   = rsp_tag_ff;
      rsp_tile_in  = rsp_tile_ff;
      rsp_frac_in  = rsp_frac_ff;
      rsp_rv_in    = rsp_rv_ff;
      rsp_mv_in    = rsp_mv_ff;
      rsp_quiet_in = rsp_quiet_ff;
      rsp_rc_in    = rsp_rc_ff;
      rsp_last_in  = rsp_last_ff;

      cell_we    = 1'b0;
      cell_waddr = '0;
      cell_wdata = sgs_pkg::CELL_EMPTY;
      cell_raddr = '0;
      ul_we      = 1'b0;
      ul_waddr   = '0;
      ul_wdata   = '0;
      ul_raddr   = '0;
      el_we      = 1'b0;
      el_waddr   = '0;
      el_wdata   = '0;
      el_raddr   = '0;
      div_start  = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            cell_we    = 1'b1;
            cell_waddr = c_ff;
            c_in       = c_ff + CW'(1);
            if (c_ff == CW'(NCELLS - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (accept) begin
               c_in   = '0;
               x_in   = '0;
               y_in   = '0;
               k_in   = '0;
               nu_in  = '0;
               ne_in  = '0;
               tdx_in = '0;
               tdy_in = '0;
               tqx_in = '0;
               tqy_in = '0;
               sum_in = '0;
               occ_in = '0;
               unh_in = '0;
               for (int n = 0; n < 16; n++) begin
                  tsum_in[n] = '0;
                  tcnt_in[n] = '0;
               end
               unique case (req_mode)
                  sgs_pkg::MODE_WRITE: begin
                     cell_we      = req_inside && (req_cell_value <= sgs_pkg::CELL_MAX);
                     cell_waddr   = addr_of(req_y, req_x);
                     cell_wdata   = req_cell_value;
                     rsp_valid_in = 1'b1;
                     rsp_tag_in   = sgs_pkg::TAG_ACK;
                     rsp_tile_in  = '0;
                     rsp_frac_in  = '0;
                     rsp_rv_in    = '0;
                     rsp_mv_in    = '0;
                     rsp_quiet_in = 1'b0;
                     rsp_rc_in    = '0;
                     rsp_last_in  = 1'b1;
                  end
                  sgs_pkg::MODE_READ: begin
                     cell_raddr   = addr_of(req_y, req_x);
                     rd_inside_in = req_inside;
                     state_in     = S_READ;
                  end
                  sgs_pkg::MODE_ROUND: begin
                     stats_in = 1'b0;
                     state_in = S_SCAN;
                  end
                  sgs_pkg::MODE_STATS: begin
                     stats_in = 1'b1;
                     state_in = S_SCAN;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end

         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_tag_in   = sgs_pkg::TAG_VALUE;
            rsp_tile_in  = '0;
            rsp_frac_in  = '0;
            rsp_rv_in    = rd_inside_ff ? cell_rdata_ff : sgs_pkg::CELL_EMPTY;
            rsp_mv_in    = '0;
            rsp_quiet_in = 1'b0;
            rsp_rc_in    = '0;
            rsp_last_in  = 1'b1;
            state_in     = S_IDLE;
         end

         // Ten steps per cell: reads go out on steps 0..8, data returns one
         // step later, and step 9 classifies the cell.
         S_SCAN: begin
            cell_raddr = addr_of(wrap_step(y_ff, dyc), wrap_step(x_ff, dxc));
            k_in = k_ff + 4'd1;
            if (k_ff == 4'd0) begin
               s_in = '0;
               t_in = '0;
            end else if (k_ff == 4'd1) begin
               me_in = cell_rdata_ff;
            end else begin
               s_in = s_nx;
               t_in = t_nx;
            end
            if (k_ff == 4'd9) begin
               k_in = '0;
               if (!stats_ff) begin
                  if (me_ff == sgs_pkg::CELL_EMPTY) begin
                     el_we    = 1'b1;
                     el_waddr = ne_ff[CW-1:0];
                     el_wdata = c_ff;
                     ne_in    = ne_ff + CNTW'(1);
                  end else if (unhappy) begin
                     ul_we    = 1'b1;
                     ul_waddr = nu_ff[CW-1:0];
                     ul_wdata = c_ff;
                     nu_in    = nu_ff + CNTW'(1);
                  end
               end else if (me_ff != sgs_pkg::CELL_EMPTY) begin
                  occ_in = occ_ff + CNTW'(1);
                  sum_in = sum_ff + SUMW'(share);
                  unh_in = unh_ff + CNTW'(unhappy);
                  if (in_tile) begin
                     tsum_in[tidx] = tsum_ff[tidx] + TSUMW'(share);
                     tcnt_in[tidx] = tcnt_ff[tidx] + TNW'(1);
                  end
               end
               // Raster advance with tile tracking.
               c_in = c_ff + CW'(1);
               if (x_ff == XW'(GRID_SIDE - 1)) begin
                  x_in   = '0;
                  tdx_in = '0;
                  tqx_in = '0;
                  y_in   = y_ff + XW'(1);
                  if (tdy_ff == TSW'(TS - 1)) begin
                     tdy_in = '0;
                     tqy_in = tqy_ff + 3'd1;
                  end else begin
                     tdy_in = tdy_ff + TSW'(1);
                  end
               end else begin
                  x_in = x_ff + XW'(1);
                  if (tdx_ff == TSW'(TS - 1)) begin
                     tdx_in = '0;
                     tqx_in = tqx_ff + 3'd1;
                  end else begin
                     tdx_in = tdx_ff + TSW'(1);
                  end
               end
               if (c_ff == CW'(NCELLS - 1)) begin
                  if (stats_ff) begin
                     didx_in  = '0;
                     state_in = S_DIV_GO;
                  end else begin
                     lsel_in  = 1'b0;
                     state_in = S_SH_PICK;
                  end
               end
            end
         end

         // Shuffle the unhappy list, then the empty list.
         S_SH_PICK: begin
            if (n_sel >= CNTW'(2)) begin
               i_in     = n_sel[CW-1:0] - CW'(1);
               state_in = S_SH_RNG;
            end else if (!lsel_ff) begin
               lsel_in = 1'b1;
            end else begin
               state_in = S_MV_CHK;
            end
         end

         S_SH_RNG: begin
            rng_in   = rprod[31:0] + sgs_pkg::LCG_INC;
            state_in = S_SH_J;
         end

         S_SH_J: begin
            j_in     = jprod[32 +: CW];
            state_in = S_SH_RDI;
         end

         S_SH_RDI: begin
            ul_raddr = i_ff;
            el_raddr = i_ff;
            state_in = S_SH_RDJ;
         end

         S_SH_RDJ: begin
            ul_raddr = j_ff;
            el_raddr = j_ff;
            ai_in    = lst_rdata;
            state_in = S_SH_WI;
         end

         S_SH_WI: begin
            ul_we    = !lsel_ff;
            el_we    = lsel_ff;
            ul_waddr = i_ff;
            el_waddr = i_ff;
            ul_wdata = lst_rdata;
            el_wdata = lst_rdata;
            state_in = S_SH_WJ;
         end

         S_SH_WJ: begin
            ul_we    = !lsel_ff;
            el_we    = lsel_ff;
            ul_waddr = j_ff;
            el_waddr = j_ff;
            ul_wdata = ai_ff;
            el_wdata = ai_ff;
            i_in     = i_ff - CW'(1);
            if (i_ff == CW'(1)) begin
               if (!lsel_ff) begin
                  lsel_in  = 1'b1;
                  state_in = S_SH_PICK;
               end else begin
                  state_in = S_MV_CHK;
               end
            end else begin
               state_in = S_SH_RNG;
            end
         end

         // The last empty slot is popped and refilled every move, so its
         // index stays at the list length minus one.
         S_MV_CHK: begin
            i_in = '0;
            if (ne_ff != '0 && nu_ff != '0) begin
               state_in = S_MV_RD;
            end else begin
               state_in = S_RND_DONE;
            end
         end

         S_MV_RD: begin
            ul_raddr = i_ff;
            el_raddr = ne_dec[CW-1:0];
            state_in = S_MV_SRC;
         end

         S_MV_SRC: begin
            src_in     = ul_rdata_ff;
            dst_in     = el_rdata_ff;
            cell_raddr = ul_rdata_ff;
            state_in   = S_MV_WD;
         end

         S_MV_WD: begin
            cell_we    = 1'b1;
            cell_waddr = dst_ff;
            cell_wdata = cell_rdata_ff;
            state_in   = S_MV_WS;
         end

         S_MV_WS: begin
            cell_we    = 1'b1;
            cell_waddr = src_ff;
            cell_wdata = sgs_pkg::CELL_EMPTY;
            el_we      = 1'b1;
            el_waddr   = ne_dec[CW-1:0];
            el_wdata   = src_ff;
            i_in       = i_ff + CW'(1);
            if (CNTW'(i_ff) == nu_dec) begin
               state_in = S_RND_DONE;
            end else begin
               state_in = S_MV_RD;
            end
         end

         S_RND_DONE: begin
            gen_in       = gen_nx;
            rsp_valid_in = 1'b1;
            rsp_tag_in   = sgs_pkg::TAG_ROUND;
            rsp_tile_in  = '0;
            rsp_frac_in  = '0;
            rsp_rv_in    = '0;
            rsp_mv_in    = mv_sat;
            rsp_quiet_in = (mv_sat == '0) && (gen_nx > 16'd1);
            rsp_rc_in    = gen_nx;
            rsp_last_in  = 1'b1;
            state_in     = S_IDLE;
         end

         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end

         S_DIV_WAIT: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               rsp_tile_in  = '0;
               rsp_frac_in  = div_quot;
               rsp_rv_in    = '0;
               rsp_mv_in    = '0;
               rsp_quiet_in = 1'b0;
               rsp_rc_in    = '0;
               rsp_last_in  = (didx_ff == sgs_pkg::STAT_LAST);
               case (didx_ff)
                  5'd0:    rsp_tag_in = sgs_pkg::TAG_MEAN;
                  5'd1:    rsp_tag_in = sgs_pkg::TAG_UNHAPPY;
                  default: begin
                     rsp_tag_in  = sgs_pkg::TAG_TILE;
                     rsp_tile_in = 4'(didx_ff - 5'd2);
                     for (int n = 0; n < 15; n++) begin
                        tsum_in[n] = tsum_ff[n + 1];
                        tcnt_in[n] = tcnt_ff[n + 1];
                     end
                  end
               endcase
               didx_in = didx_ff + 5'd1;
               if (didx_ff == sgs_pkg::STAT_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_DIV_GO;
               end
            end
         end

         default: state_in = S_IDLE;
      endcase

      // Configuration writes must arrive only while the block is idle; the block does not enforce it.
      if (csr_we) begin
         if (csr_index == sgs_pkg::CSR_TOLERANCE) begin
            tol_in = csr_wdata[8:0];
         end else begin
            rng_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         c_ff         <= '0;
         tol_ff       <= sgs_pkg::TOL_RESET;
         rng_ff       <= sgs_pkg::SEED_RESET;
         gen_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         c_ff         <= c_in;
         tol_ff       <= tol_in;
         rng_ff       <= rng_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stats_ff     <= stats_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      k_ff         <= k_in;
      me_ff        <= me_in;
      s_ff         <= s_in;
      t_ff         <= t_in;
      nu_ff        <= nu_in;
      ne_ff        <= ne_in;
      tdx_ff       <= tdx_in;
      tdy_ff       <= tdy_in;
      tqx_ff       <= tqx_in;
      tqy_ff       <= tqy_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      ai_ff        <= ai_in;
      src_ff       <= src_in;
      dst_ff       <= dst_in;
      lsel_ff      <= lsel_in;
      rd_inside_ff <= rd_inside_in;
      sum_ff       <= sum_in;
      occ_ff       <= occ_in;
      unh_ff       <= unh_in;
      didx_ff      <= didx_in;
      for (int n = 0; n < 16; n++) begin
         tsum_ff[n] <= tsum_in[n];
         tcnt_ff[n] <= tcnt_in[n];
      end
      rsp_tag_ff   <= rsp_tag_in;
      rsp_tile_ff  <= rsp_tile_in;
      rsp_frac_ff  <= rsp_frac_in;
      rsp_rv_ff    <= rsp_rv_in;
      rsp_mv_ff    <= rsp_mv_in;
      rsp_quiet_ff <= rsp_quiet_in;
      rsp_rc_ff    <= rsp_rc_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_tag  = rsp_tag_ff;
   assign rsp_tile_index  = rsp_tile_ff;
   assign rsp_fraction    = rsp_frac_ff;
   assign rsp_read_value  = rsp_rv_ff;
   assign rsp_moves       = rsp_mv_ff;
   assign rsp_quiet       = rsp_quiet_ff;
   assign rsp_round_count = rsp_rc_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
